[design/rtnp_pkg.sv]
// shared types and constants for the ray triangle nearest pick unit
package rtnp_pkg;

	localparam int COORD_W = 32;
	localparam int DIFF_W = 33;
	localparam int WIDE_W = 128;
	localparam int DIST_W = 31;
	localparam logic [DIST_W-1:0] DIST_MAX = {DIST_W{1'b1}};

	localparam logic [2:0] REG_ORIGIN_X = 3'd0;
	localparam logic [2:0] REG_ORIGIN_Y = 3'd1;
	localparam logic [2:0] REG_ORIGIN_Z = 3'd2;
	localparam logic [2:0] REG_DIR_X = 3'd3;
	localparam logic [2:0] REG_DIR_Y = 3'd4;
	localparam logic [2:0] REG_DIR_Z = 3'd5;

	typedef logic signed [WIDE_W-1:0] wide_t;

	typedef struct packed {
		logic start;
		logic busy;
		logic done;
	} div_ctl_t;

endpackage

[design/rtnp_div.sv]
// restoring divider, one quotient bit per cycle
module rtnp_div (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	input  logic [rtnp_pkg::WIDE_W-1:0] num,
	input  logic [rtnp_pkg::WIDE_W-1:0] den,
	output rtnp_pkg::div_ctl_t ctl,
	output logic [rtnp_pkg::WIDE_W-1:0] quo
);
	logic [rtnp_pkg::WIDE_W-1:0] num_q;
	logic [rtnp_pkg::WIDE_W-1:0] den_q;
	logic [rtnp_pkg::WIDE_W:0] rem_q;
	logic [6:0] cnt_q;
	logic busy_q;
	logic done_q;
	logic [rtnp_pkg::WIDE_W:0] shifted;
	logic [rtnp_pkg::WIDE_W:0] diff;

	assign shifted = {rem_q[rtnp_pkg::WIDE_W-1:0], num_q[rtnp_pkg::WIDE_W-1]};
	assign diff = shifted - {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 7'd1;
				if (cnt_q == 7'd127) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= num;
			den_q <= den;
			rem_q <= '0;
			quo <= '0;
		end else if (busy_q) begin
			num_q <= {num_q[rtnp_pkg::WIDE_W-2:0], 1'b0};
			if (!diff[rtnp_pkg::WIDE_W]) begin
				rem_q <= diff;
				quo <= {quo[rtnp_pkg::WIDE_W-2:0], 1'b1};
			end else begin
				rem_q <= shifted;
				quo <= {quo[rtnp_pkg::WIDE_W-2:0], 1'b0};
			end
		end
	end

	assign ctl.start = start;
	assign ctl.busy = busy_q;
	assign ctl.done = done_q;
endmodule

[design/ray_triangle_nearest_pick_unit.sv]
// ray triangle nearest pick unit: top level with sequencer and shared multiply-add unit
//
// usage: write the ray origin and direction through the cfg port (index 0..5) while idle.
// stream triangles on the s_axis channel; tdata holds ax,ay,az,bx,by,bz,cx,cy,cz,face_tag,
// tuser holds last_triangle. each request is worked through by a sequencer that drives
// one shared 33x34 signed multiplier with an accumulator: 24 product steps (edge
// cross products in one pass each, dot products in two passes over the operand halves),
// then a restoring divider for the distance, then three hit-point products on the
// last triangle.
// a triangle holds the input until it is done: one that misses or is degenerate skips the
// divider, one that reaches it waits for the quotient, and a last triangle adds the hit
// point and the result. the divider sets the worst case.
// s_axis_tready is low while a triangle is in work.
// on a last triangle one result goes out on m_axis: tdata holds hit_found, hit_face,
// hit_distance, hit_x, hit_y, hit_z. the result sits in an output register; the
// next triangle is taken while it waits, but a later last triangle holds until the
// result has been taken.
// reset clears the best hit, loads the default ray (direction +z) and empties the
// output register.
module ray_triangle_nearest_pick_unit #(
	parameter int FRAC_BITS = 16,
	parameter int FACE_ID_BITS = 16
) (
	input  logic clk,
	input  logic arst_n,
	input  logic cfg_we,
	input  logic [2:0] cfg_index,
	input  logic [31:0] cfg_data,
	input  logic s_axis_tvalid,
	output logic s_axis_tready,
	// ax, ay, az, bx, by, bz, cx, cy, cz, face_tag
	input  logic [303:0] s_axis_tdata,
	// last_triangle
	input  logic s_axis_tuser,
	output logic m_axis_tvalid,
	input  logic m_axis_tready,
	// hit_found, hit_face, hit_distance, hit_x, hit_y, hit_z
	output logic [151:0] m_axis_tdata
);
	localparam int W = rtnp_pkg::WIDE_W;
	localparam int MW = 66;

	localparam logic [3:0] ST_IDLE = 4'd0;
	localparam logic [3:0] ST_MUL = 4'd1;
	localparam logic [3:0] ST_CHECK = 4'd2;
	localparam logic [3:0] ST_DIV = 4'd3;
	localparam logic [3:0] ST_DWAIT = 4'd4;
	localparam logic [3:0] ST_UPD = 4'd5;
	localparam logic [3:0] ST_PT = 4'd6;
	localparam logic [3:0] ST_OUT = 4'd7;

	logic signed [31:0] org_q [3];
	logic signed [31:0] dir_q [3];
	logic signed [32:0] e1_q [3];
	logic signed [32:0] e2_q [3];
	logic signed [32:0] s_q [3];
	logic signed [MW-1:0] p_q [3];
	logic signed [MW-1:0] qv_q [3];
	logic signed [W-1:0] det_q, un_q, vn_q, tn_q, acc_q;
	logic [FACE_ID_BITS-1:0] face_q;
	logic last_q;
	logic [3:0] state_q;
	logic [5:0] step_q;
	logic half_q;
	logic best_valid_q;
	logic [rtnp_pkg::DIST_W-1:0] best_dist_q;
	logic [FACE_ID_BITS-1:0] best_face_q;
	logic signed [31:0] pt_q [3];
	logic [1:0] axis_q;
	logic out_valid_q;
	logic [151:0] out_data_q;

	logic signed [32:0] ma;
	logic signed [MW-1:0] mb;
	logic signed [33:0] mb_part;
	logic dot_step;
	logic signed [66:0] prod;
	logic signed [W-1:0] prod_w;
	rtnp_pkg::div_ctl_t dctl;
	logic [W-1:0] quo;
	logic dstart;
	logic [W-1:0] dnum;
	logic signed [W-1:0] adet, aun, avn, atn, uvsum;
	logic [rtnp_pkg::DIST_W-1:0] tsat;
	logic signed [63:0] pprod;
	logic signed [63:0] pq;
	logic signed [64:0] pc;
	logic signed [31:0] psat;

	function automatic logic signed [MW-1:0] sx33(input logic signed [32:0] v);
		return MW'(v);
	endfunction

	// operand schedule for the shared multiplier
	always_comb begin
		ma = '0;
		mb = '0;
		unique case (step_q)
			6'd0: begin ma = 33'(dir_q[1]); mb = sx33(e2_q[2]); end
			6'd1: begin ma = 33'(dir_q[2]); mb = sx33(e2_q[1]); end
			6'd2: begin ma = 33'(dir_q[2]); mb = sx33(e2_q[0]); end
			6'd3: begin ma = 33'(dir_q[0]); mb = sx33(e2_q[2]); end
			6'd4: begin ma = 33'(dir_q[0]); mb = sx33(e2_q[1]); end
			6'd5: begin ma = 33'(dir_q[1]); mb = sx33(e2_q[0]); end
			6'd6: begin ma = s_q[1]; mb = sx33(e1_q[2]); end
			6'd7: begin ma = s_q[2]; mb = sx33(e1_q[1]); end
			6'd8: begin ma = s_q[2]; mb = sx33(e1_q[0]); end
			6'd9: begin ma = s_q[0]; mb = sx33(e1_q[2]); end
			6'd10: begin ma = s_q[0]; mb = sx33(e1_q[1]); end
			6'd11: begin ma = s_q[1]; mb = sx33(e1_q[0]); end
			6'd12: begin ma = e1_q[0]; mb = p_q[0]; end
			6'd13: begin ma = e1_q[1]; mb = p_q[1]; end
			6'd14: begin ma = e1_q[2]; mb = p_q[2]; end
			6'd15: begin ma = s_q[0]; mb = p_q[0]; end
			6'd16: begin ma = s_q[1]; mb = p_q[1]; end
			6'd17: begin ma = s_q[2]; mb = p_q[2]; end
			6'd18: begin ma = 33'(dir_q[0]); mb = qv_q[0]; end
			6'd19: begin ma = 33'(dir_q[1]); mb = qv_q[1]; end
			6'd20: begin ma = 33'(dir_q[2]); mb = qv_q[2]; end
			6'd21: begin ma = e2_q[0]; mb = qv_q[0]; end
			6'd22: begin ma = e2_q[1]; mb = qv_q[1]; end
			6'd23: begin ma = e2_q[2]; mb = qv_q[2]; end
			default: begin ma = '0; mb = '0; end
		endcase
	end

	// dot products take the low half unsigned, then the high half signed
	assign dot_step = (step_q >= 6'd12);
	assign mb_part = !dot_step ? $signed({mb[32], mb[32:0]})
		: !half_q ? $signed({1'b0, mb[32:0]})
		: $signed({mb[MW-1], mb[MW-1:33]});

	assign prod = ma * mb_part;
	assign prod_w = half_q ? (W'(prod) <<< 33) : W'(prod);

	assign adet = det_q[W-1] ? -det_q : det_q;
	assign aun = det_q[W-1] ? -un_q : un_q;
	assign avn = det_q[W-1] ? -vn_q : vn_q;
	assign atn = det_q[W-1] ? -tn_q : tn_q;
	assign uvsum = aun + avn;
	assign dnum = W'(atn) << FRAC_BITS;
	assign dstart = (state_q == ST_DIV);

	rtnp_div u_div (
		.clk(clk),
		.arst_n(arst_n),
		.start(dstart),
		.num(dnum),
		.den(adet),
		.ctl(dctl),
		.quo(quo)
	);

	assign tsat = (quo[W-1:rtnp_pkg::DIST_W] != '0) ? rtnp_pkg::DIST_MAX
		: quo[rtnp_pkg::DIST_W-1:0];

	// hit point: one axis per cycle through a 32x32 product
	assign pprod = 64'(dir_q[axis_q]) * $signed({33'd0, best_dist_q});
	assign pq = pprod >>> FRAC_BITS;
	assign pc = 65'(org_q[axis_q]) + 65'(pq);
	assign psat = (pc > 65'sh7FFFFFFF) ? 32'sh7FFFFFFF
		: (pc < -65'sh80000000) ? -32'sh80000000 : pc[31:0];

	assign s_axis_tready = (state_q == ST_IDLE) && !(s_axis_tuser && out_valid_q);
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata = out_data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			org_q[0] <= '0; org_q[1] <= '0; org_q[2] <= '0;
			dir_q[0] <= '0; dir_q[1] <= '0; dir_q[2] <= 32'sd65536;
		end else if (cfg_we) begin
			unique case (cfg_index)
				rtnp_pkg::REG_ORIGIN_X: org_q[0] <= cfg_data;
				rtnp_pkg::REG_ORIGIN_Y: org_q[1] <= cfg_data;
				rtnp_pkg::REG_ORIGIN_Z: org_q[2] <= cfg_data;
				rtnp_pkg::REG_DIR_X: dir_q[0] <= cfg_data;
				rtnp_pkg::REG_DIR_Y: dir_q[1] <= cfg_data;
				rtnp_pkg::REG_DIR_Z: dir_q[2] <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			step_q <= '0;
			half_q <= 1'b0;
			axis_q <= '0;
			best_valid_q <= 1'b0;
			best_dist_q <= '0;
			best_face_q <= '0;
			out_valid_q <= 1'b0;
			last_q <= 1'b0;
		end else begin
			if (out_valid_q && m_axis_tready) out_valid_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (s_axis_tvalid && s_axis_tready) begin
						last_q <= s_axis_tuser;
						step_q <= '0;
						half_q <= 1'b0;
						state_q <= ST_MUL;
					end
				end
				ST_MUL: begin
					if (dot_step && !half_q) begin
						half_q <= 1'b1;
					end else begin
						half_q <= 1'b0;
						step_q <= step_q + 6'd1;
						if (step_q == 6'd23) state_q <= ST_CHECK;
					end
				end
				ST_CHECK: begin
					if (det_q != '0 && !aun[W-1] && !avn[W-1] && !(uvsum > adet)
						&& !atn[W-1] && atn != '0)
						state_q <= ST_DIV;
					else
						state_q <= ST_UPD;
				end
				ST_DIV: state_q <= ST_DWAIT;
				ST_DWAIT: begin
					if (dctl.done) begin
						if (tsat != '0 && (!best_valid_q || tsat < best_dist_q)) begin
							best_valid_q <= 1'b1;
							best_dist_q <= tsat;
							best_face_q <= (face_q != '0) ? face_q : FACE_ID_BITS'(1);
						end
						state_q <= ST_UPD;
					end
				end
				ST_UPD: begin
					axis_q <= '0;
					state_q <= last_q ? ST_PT : ST_IDLE;
				end
				ST_PT: begin
					axis_q <= axis_q + 2'd1;
					if (axis_q == 2'd2) state_q <= ST_OUT;
				end
				ST_OUT: begin
					out_valid_q <= 1'b1;
					best_valid_q <= 1'b0;
					best_dist_q <= '0;
					best_face_q <= '0;
					state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && s_axis_tvalid && s_axis_tready) begin
			for (int i = 0; i < 3; i++) begin
				e1_q[i] <= 33'($signed(s_axis_tdata[96+32*i +: 32]))
					- 33'($signed(s_axis_tdata[32*i +: 32]));
				e2_q[i] <= 33'($signed(s_axis_tdata[192+32*i +: 32]))
					- 33'($signed(s_axis_tdata[32*i +: 32]));
				s_q[i] <= 33'(org_q[i]) - 33'($signed(s_axis_tdata[32*i +: 32]));
			end
			face_q <= FACE_ID_BITS'(s_axis_tdata[288 +: 16]);
			acc_q <= '0;
		end
		if (state_q == ST_MUL) begin
			if (step_q < 6'd12) begin
				if (!step_q[0]) acc_q <= prod_w;
				else if (step_q < 6'd6) p_q[step_q[2:1]] <= MW'(acc_q - prod_w);
				else qv_q[2'((step_q - 6'd6) >> 1)] <= MW'(acc_q - prod_w);
			end else begin
				if (!half_q && (step_q == 6'd12 || step_q == 6'd15 || step_q == 6'd18
					|| step_q == 6'd21))
					acc_q <= prod_w;
				else
					acc_q <= acc_q + prod_w;
				if (half_q && step_q == 6'd14) det_q <= acc_q + prod_w;
				if (half_q && step_q == 6'd17) un_q <= acc_q + prod_w;
				if (half_q && step_q == 6'd20) vn_q <= acc_q + prod_w;
				if (half_q && step_q == 6'd23) tn_q <= acc_q + prod_w;
			end
		end
		if (state_q == ST_PT) pt_q[axis_q] <= psat;
		if (state_q == ST_OUT) begin
			if (best_valid_q)
				out_data_q <= {8'd0, pt_q[2], pt_q[1], pt_q[0], best_dist_q,
					16'(best_face_q), 1'b1};
			else
				out_data_q <= '0;
		end
	end

	a_busy_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_IDLE) |-> !s_axis_tready)
		else $error("input taken while busy");
	a_out_once: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_OUT) |=> (state_q == ST_IDLE && !best_valid_q))
		else $error("best hit not cleared after result");
	a_hit_dist: assert property (@(posedge clk) disable iff (!arst_n)
		best_valid_q |-> (best_dist_q != '0))
		else $error("stored hit with zero distance");
endmodule
